[hdl/mips_integer_alu_hi_lo_assert.svh]
// assertion macros shared by the alu modules
`ifndef MIPS_INTEGER_ALU_HI_LO_ASSERT_SVH
`define MIPS_INTEGER_ALU_HI_LO_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define MIA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define MIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mia_pkg.sv]
// shared constants and types of the mips integer alu
package mia_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int CMD_W     = 5;
  localparam int SHAMT_W   = 5;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int OUTC_W    = 2;
  localparam int LUI_SHIFT = 16;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  // operation codes
  localparam logic [CMD_W-1:0] CMD_SLL     = 5'd0;
  localparam logic [CMD_W-1:0] CMD_SRL     = 5'd1;
  localparam logic [CMD_W-1:0] CMD_AND     = 5'd2;
  localparam logic [CMD_W-1:0] CMD_OR      = 5'd3;
  localparam logic [CMD_W-1:0] CMD_XOR     = 5'd4;
  localparam logic [CMD_W-1:0] CMD_NOR     = 5'd5;
  localparam logic [CMD_W-1:0] CMD_PASS_A  = 5'd6;
  localparam logic [CMD_W-1:0] CMD_SLT     = 5'd7;
  localparam logic [CMD_W-1:0] CMD_SLTU    = 5'd8;
  localparam logic [CMD_W-1:0] CMD_ADD     = 5'd9;
  localparam logic [CMD_W-1:0] CMD_ADDU    = 5'd10;
  localparam logic [CMD_W-1:0] CMD_SUB     = 5'd11;
  localparam logic [CMD_W-1:0] CMD_SUBU    = 5'd12;
  localparam logic [CMD_W-1:0] CMD_MULT    = 5'd13;
  localparam logic [CMD_W-1:0] CMD_MULTU   = 5'd14;
  localparam logic [CMD_W-1:0] CMD_DIV     = 5'd15;
  localparam logic [CMD_W-1:0] CMD_DIVU    = 5'd16;
  localparam logic [CMD_W-1:0] CMD_LUI     = 5'd17;
  localparam logic [CMD_W-1:0] CMD_SYSCALL = 5'd18;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTC_OK      = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_UNDEF   = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_DIVZERO = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_SYSCALL = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MULT_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_DELAY  = 1'd1;

  localparam logic [CFG_W-1:0] MULT_DELAY_RST = 8'd4;
  localparam logic [CFG_W-1:0] DIV_DELAY_RST  = 8'd12;

  // sequencer to mul/div unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  // mul/div unit back to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

[hdl/mia_chan_if.sv]
// valid/ready channel interfaces for alu operations and results
interface mia_in_if;
  logic                           valid;
  logic                           ready;
  logic [mia_pkg::CMD_W-1:0]      command;
  logic [mia_pkg::DATA_W-1:0]     operand_a;
  logic [mia_pkg::DATA_W-1:0]     operand_b;
  logic [mia_pkg::SHAMT_W-1:0]    shamt;

  modport source (output valid, command, operand_a, operand_b, shamt, input ready);
  modport sink (input valid, command, operand_a, operand_b, shamt, output ready);
endinterface

interface mia_out_if;
  logic                           valid;
  logic                           ready;
  logic [mia_pkg::DATA_W-1:0]     result;
  logic [mia_pkg::DATA_W-1:0]     hi_value;
  logic [mia_pkg::DATA_W-1:0]     lo_value;
  logic [mia_pkg::CFG_W-1:0]      stall_cycles;
  logic [mia_pkg::OUTC_W-1:0]     outcome;

  modport source (output valid, result, hi_value, lo_value, stall_cycles, outcome, input ready);
  modport sink (input valid, result, hi_value, lo_value, stall_cycles, outcome, output ready);
endinterface

[hdl/mips_integer_alu_hi_lo.sv]
// mips32 integer alu with hi/lo registers and an iterative multiply/divide unit
//
//   channel   dir  handshake         carries
//   in_i      in   valid / ready     command, operand_a, operand_b, shamt
//   out_o     out  valid / ready     result, hi_value, lo_value, stall_cycles, outcome
//   cfg       in   cfg_we_i          cfg_idx_i, cfg_data_i (mult_delay, div_delay)
//
// simple operations, divide by zero, syscall and undefined codes: result is
// registered in the accept cycle and shows on out_o in the cycle after
// mult, multu, div, divu: 32 steps of the shared adder unit, then done moves the sequencer
// to a sign fix-up state, which registers the result once out_o has room
// in_i.ready is low while the unit runs and while a result waits on out_o
// reset clears hi/lo, sets mult_delay to 4 and div_delay to 12
`include "mips_integer_alu_hi_lo_assert.svh"

module mips_integer_alu_hi_lo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mia_in_if.sink                          in_i,
  mia_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [mia_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mia_pkg::CFG_W-1:0]       cfg_data_i
);
  import mia_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIX
  } state_e;

  state_e            state_q;
  logic [DATA_W-1:0] hi_q, lo_q;
  logic [CFG_W-1:0]  mult_delay_q, div_delay_q;
  logic              neg_q, rneg_q, div_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_result_q, out_hi_q, out_lo_q;
  logic [CFG_W-1:0]  out_stall_q;
  logic [OUTC_W-1:0] out_outcome_q;

  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] opa, opb;
  logic              in_fire, slot_free, out_load;
  logic              is_mul, is_div, is_signed, b_zero, a_neg, b_neg;
  logic [DATA_W-1:0] a_mag, b_mag;
  logic [DATA_W-1:0] alu_res;
  logic [OUTC_W-1:0] alu_outcome;

  md_ctrl_t          md_ctrl;
  md_stat_t          md_stat;
  logic [DATA_W-1:0] md_hi, md_lo;

  logic [2*DATA_W-1:0] prod_fix;
  logic [DATA_W-1:0]   q_fix, r_fix, fix_hi, fix_lo;

  assign cmd = in_i.command;
  assign opa = in_i.operand_a;
  assign opb = in_i.operand_b;

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && slot_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign is_mul    = (cmd == CMD_MULT) || (cmd == CMD_MULTU);
  assign is_div    = (cmd == CMD_DIV) || (cmd == CMD_DIVU);
  assign is_signed = (cmd == CMD_MULT) || (cmd == CMD_DIV);
  assign b_zero    = (opb == '0);
  assign a_neg     = is_signed && opa[DATA_W-1];
  assign b_neg     = is_signed && opb[DATA_W-1];
  assign a_mag     = a_neg ? ('0 - opa) : opa;
  assign b_mag     = b_neg ? ('0 - opb) : opb;

  assign md_ctrl.start  = in_fire && (is_mul || (is_div && !b_zero));
  assign md_ctrl.is_div = is_div;

  // a new result beat is loaded either from the alu or from the fix-up stage
  assign out_load = (in_fire && !md_ctrl.start) || ((state_q == S_FIX) && slot_free);

  always_comb begin
    alu_res     = ALL_ONES;
    alu_outcome = OUTC_OK;
    case (cmd)
      CMD_SLL:     alu_res = opb << in_i.shamt;
      CMD_SRL:     alu_res = opb >> in_i.shamt;
      CMD_AND:     alu_res = opa & opb;
      CMD_OR:      alu_res = opa | opb;
      CMD_XOR:     alu_res = opa ^ opb;
      CMD_NOR:     alu_res = ~(opa | opb);
      CMD_PASS_A:  alu_res = opa;
      CMD_SLT:     alu_res = {{(DATA_W-1){1'b0}}, $signed(opa) < $signed(opb)};
      CMD_SLTU:    alu_res = {{(DATA_W-1){1'b0}}, opa < opb};
      CMD_ADD,
      CMD_ADDU:    alu_res = opa + opb;
      CMD_SUB,
      CMD_SUBU:    alu_res = opa - opb;
      CMD_MULT,
      CMD_MULTU:   alu_outcome = OUTC_OK;
      CMD_DIV,
      CMD_DIVU:    alu_outcome = b_zero ? OUTC_DIVZERO : OUTC_OK;
      CMD_LUI:     alu_res = opb << LUI_SHIFT;
      CMD_SYSCALL: alu_outcome = OUTC_SYSCALL;
      default:     alu_outcome = OUTC_UNDEF;
    endcase
  end

  mia_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (md_ctrl),
    .a_i    (a_mag),
    .b_i    (b_mag),
    .stat_o (md_stat),
    .hi_o   (md_hi),
    .lo_o   (md_lo)
  );

  // sign fix-up of the magnitude results
  always_comb begin
    prod_fix = neg_q ? ('0 - {md_hi, md_lo}) : {md_hi, md_lo};
    q_fix    = neg_q ? ('0 - md_lo) : md_lo;
    r_fix    = rneg_q ? ('0 - md_hi) : md_hi;
    fix_hi   = div_q ? r_fix : prod_fix[2*DATA_W-1:DATA_W];
    fix_lo   = div_q ? q_fix : prod_fix[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      hi_q          <= '0;
      lo_q          <= '0;
      mult_delay_q  <= MULT_DELAY_RST;
      div_delay_q   <= DIV_DELAY_RST;
      neg_q         <= 1'b0;
      rneg_q        <= 1'b0;
      div_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      out_result_q  <= '0;
      out_hi_q      <= '0;
      out_lo_q      <= '0;
      out_stall_q   <= '0;
      out_outcome_q <= OUTC_OK;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MULT_DELAY: mult_delay_q <= cfg_data_i;
          REG_DIV_DELAY:  div_delay_q  <= cfg_data_i;
          default:        ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (md_ctrl.start) begin
              neg_q   <= a_neg ^ b_neg;
              rneg_q  <= a_neg;
              div_q   <= is_div;
              state_q <= S_RUN;
            end else begin
              out_result_q  <= alu_res;
              out_hi_q      <= hi_q;
              out_lo_q      <= lo_q;
              out_stall_q   <= '0;
              out_outcome_q <= alu_outcome;
            end
          end
        end
        S_RUN: begin
          if (md_stat.done) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          // wait here until the previous beat has left
          if (slot_free) begin
            hi_q          <= fix_hi;
            lo_q          <= fix_lo;
            out_result_q  <= ALL_ONES;
            out_hi_q      <= fix_hi;
            out_lo_q      <= fix_lo;
            out_stall_q   <= div_q ? div_delay_q : mult_delay_q;
            out_outcome_q <= OUTC_OK;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result       = out_result_q;
  assign out_o.hi_value     = out_hi_q;
  assign out_o.lo_value     = out_lo_q;
  assign out_o.stall_cycles = out_stall_q;
  assign out_o.outcome      = out_outcome_q;

  `MIA_ASSERT_NEXT(a_start_run, md_ctrl.start, state_q == S_RUN && md_stat.busy, "mul/div did not enter run")
  `MIA_ASSERT_IMPLY(a_done_in_run, md_stat.done, state_q == S_RUN, "unit finished outside run")
  `MIA_ASSERT_NEXT(a_hi_hold, state_q != S_FIX, hi_q == $past(hi_q), "hi changed outside fix-up")
  `MIA_ASSERT_NEXT(a_lo_hold, state_q != S_FIX, lo_q == $past(lo_q), "lo changed outside fix-up")

endmodule

[hdl/mia_muldiv.sv]
// bit-serial unsigned multiply and restoring divide on one shared adder
`include "mips_integer_alu_hi_lo_assert.svh"

module mia_muldiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mia_pkg::md_ctrl_t            ctrl_i,
  input  logic [mia_pkg::DATA_W-1:0]   a_i,
  input  logic [mia_pkg::DATA_W-1:0]   b_i,
  output mia_pkg::md_stat_t            stat_o,
  output logic [mia_pkg::DATA_W-1:0]   hi_o,
  output logic [mia_pkg::DATA_W-1:0]   lo_o
);
  import mia_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

  logic [DATA_W-1:0] r_q, r_d;
  logic [DATA_W-1:0] l_q, l_d;
  logic [DATA_W-1:0] b_q;
  logic              div_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   add_x;
  logic [DATA_W:0]   add_y;
  logic [DATA_W+1:0] sum;
  logic              carry;

  // multiply: add multiplicand when lsb set, shift right
  // divide: shift left, subtract divisor when it fits (carry out = no borrow)
  always_comb begin
    shifted = {r_q, l_q[DATA_W-1]};
    add_x   = div_q ? shifted : {1'b0, r_q};
    add_y   = div_q ? ~{1'b0, b_q} : (l_q[0] ? {1'b0, b_q} : '0);
    sum     = {1'b0, add_x} + {1'b0, add_y} + {{(DATA_W+1){1'b0}}, div_q};
    carry   = sum[DATA_W+1];
    if (div_q) begin
      r_d = carry ? sum[DATA_W-1:0] : shifted[DATA_W-1:0];
      l_d = {l_q[DATA_W-2:0], carry};
    end else begin
      r_d = sum[DATA_W:1];
      l_d = {sum[0], l_q[DATA_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !ctrl_i.start && (cnt_q == LAST);
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      r_q   <= '0;
      l_q   <= a_i;
      b_q   <= b_i;
      div_q <= ctrl_i.is_div;
    end else if (busy_q) begin
      r_q <= r_d;
      l_q <= l_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign hi_o        = r_q;
  assign lo_o        = l_q;

  `MIA_ASSERT_NEXT(a_start_busy, ctrl_i.start, busy_q && cnt_q == '0, "unit did not start")
  `MIA_ASSERT_NEXT(a_last_done, busy_q && !ctrl_i.start && cnt_q == LAST, done_q && !busy_q, "unit missed its last step")
  `MIA_ASSERT_IMPLY(a_done_idle, done_q, !busy_q, "unit done while still busy")

endmodule
